### hw/rtl/lkrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkrt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int PICK_W      = SLOT_W + 1;

   // input modes
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_PING  = 3'd1;
   localparam logic [2:0] MODE_PONG  = 3'd2;
   localparam logic [2:0] MODE_RESP  = 3'd3;
   localparam logic [2:0] MODE_OTHER = 3'd4;
   localparam logic [2:0] MODE_NEW   = 3'd5;
   localparam logic [2:0] MODE_CLOSE = 3'd6;
   localparam logic [2:0] MODE_QUERY = 3'd7;

   // result kinds
   localparam logic [3:0] KIND_PING      = 4'd0;
   localparam logic [3:0] KIND_PONG      = 4'd1;
   localparam logic [3:0] KIND_SEND      = 4'd2;
   localparam logic [3:0] KIND_LINK_UP   = 4'd3;
   localparam logic [3:0] KIND_LINK_DOWN = 4'd4;
   localparam logic [3:0] KIND_STALE     = 4'd5;
   localparam logic [3:0] KIND_TIMED_OUT = 4'd6;
   localparam logic [3:0] KIND_REMOVED   = 4'd7;
   localparam logic [3:0] KIND_CLOSE_RES = 4'd8;
   localparam logic [3:0] KIND_QUERY_RES = 4'd9;
   localparam logic [3:0] KIND_FULL      = 4'd10;

   // slot status
   localparam logic [1:0] ST_SENT    = 2'd0;
   localparam logic [1:0] ST_OK      = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_CLOSED  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_PING_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_QUIET         = 2'd1;
   localparam logic [1:0] CSR_LOST_AFTER    = 2'd2;
   localparam logic [1:0] CSR_STALE_LIMIT   = 2'd3;

   localparam logic [15:0] PING_INTERVAL_RST = 16'd500;
   localparam logic [15:0] QUIET_RST         = 16'd2000;
   localparam logic [15:0] LOST_AFTER_RST    = 16'd4000;
   localparam logic [15:0] STALE_LIMIT_RST   = 16'd1000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] now_ms;
      logic [31:0] request_id;
      logic [30:0] timeout_ms;
      logic [31:0] response_data;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] result_id;
      logic        found;
      logic [31:0] result_data;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] id;
      logic [31:0] sent_time;
      logic [30:0] timeout;
      logic [31:0] response;
   } slot_word_type;

endpackage

`default_nettype wire

### hw/rtl/link_keepalive_request_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// tick: rank ids (S_RANK), sweep slots in id order (S_PICK), then S_PING, S_LOST, S_FIN
// response, close, query: S_LOOK then S_FIN; ping, pong, other line, new request: S_FIN
// results leave one per cycle on rsp_strobe, the last one in the first cycle with busy low
// the slot memory has one read and one write port; the sweep rate is set by its read port
// reset clears valid bits, id counter, link state, times and registers at once; no clearing pass
// the receiver cannot stall: every strobed beat is taken
module link_keepalive_request_tracker_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  lkrt_pkg::req_type     req_data,
   output logic                  rsp_strobe,
   output lkrt_pkg::rsp_type     rsp_data,
   input  wire                   csr_we,
   input  wire  [1:0]            csr_index,
   input  wire  [15:0]           csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RANK = 3'd1;
   localparam logic [2:0] S_PICK = 3'd2;
   localparam logic [2:0] S_PING = 3'd3;
   localparam logic [2:0] S_LOST = 3'd4;
   localparam logic [2:0] S_LOOK = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   localparam int DEPTH = lkrt_pkg::TABLE_DEPTH;
   localparam int SW    = lkrt_pkg::SLOT_W;
   localparam int PW    = lkrt_pkg::PICK_W;

   logic [2:0]  state_ff, state_in;
   lkrt_pkg::req_type item_ff, item_in;

   logic [15:0] ping_interval_ff, ping_interval_in;
   logic [15:0] quiet_ff, quiet_in;
   logic [15:0] lost_after_ff, lost_after_in;
   logic [15:0] stale_limit_ff, stale_limit_in;

   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [DEPTH-1:0] snap_ff, snap_in;
   logic [31:0]      id_ff [DEPTH];
   logic [31:0]      id_in [DEPTH];
   logic [SW-1:0]    rank_ff [DEPTH];
   logic [SW-1:0]    rank_in [DEPTH];

   logic [31:0] next_id_ff, next_id_in;
   logic        link_up_ff, link_up_in;
   logic [31:0] last_ping_ff, last_ping_in;
   logic [31:0] last_rx_ff, last_rx_in;
   logic        ping_due_ff, ping_due_in;
   logic        lost_ff, lost_in;

   logic [SW-1:0] scan_ff, scan_in;
   logic [PW-1:0] pick_ff, pick_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [SW-1:0] rd_slot_ff, rd_slot_in;
   logic          look_hit_ff, look_hit_in;
   logic [SW-1:0] look_slot_ff, look_slot_in;

   logic              hold_valid_ff, hold_valid_in;
   lkrt_pkg::rsp_type hold_ff, hold_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   lkrt_pkg::rsp_type rsp_ff, rsp_in;

   // slot memory
   lkrt_pkg::slot_word_type mem [DEPTH];
   lkrt_pkg::slot_word_type mem_rdata_ff;
   lkrt_pkg::slot_word_type mem_wdata;
   logic                    mem_we, mem_re;
   logic [SW-1:0]           mem_waddr, mem_raddr;

   // lookups over the tag flops
   logic          req_hit, nid_hit, free_any, pick_any;
   logic [SW-1:0] req_slot, free_slot, pick_slot;

   logic              new_valid, fin;
   lkrt_pkg::rsp_type new_rsp;
   lkrt_pkg::slot_word_type w;
   logic [31:0]       age;
   logic [31:0]       scan_id;
   logic              scan_ok;

   always_comb begin
      req_hit   = 1'b0;
      req_slot  = '0;
      nid_hit   = 1'b0;
      free_any  = 1'b0;
      free_slot = '0;
      pick_any  = 1'b0;
      pick_slot = '0;
      // descending so the lowest index wins
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (valid_ff[i] && id_ff[i] == req_data.request_id) begin
            req_hit  = 1'b1;
            req_slot = SW'(i);
         end
         if (valid_ff[i] && id_ff[i] == next_id_ff) begin
            nid_hit = 1'b1;
         end
         if (!valid_ff[i]) begin
            free_any  = 1'b1;
            free_slot = SW'(i);
         end
         if (snap_ff[i] && !pick_ff[PW-1] && rank_ff[i] == pick_ff[SW-1:0]) begin
            pick_any  = 1'b1;
            pick_slot = SW'(i);
         end
      end
   end

   assign scan_id = id_ff[scan_ff];
   assign scan_ok = snap_ff[scan_ff];
   assign age     = item_ff.now_ms - mem_rdata_ff.sent_time;

   always_comb begin
      state_in         = state_ff;
      item_in          = item_ff;
      ping_interval_in = ping_interval_ff;
      quiet_in         = quiet_ff;
      lost_after_in    = lost_after_ff;
      stale_limit_in   = stale_limit_ff;
      valid_in         = valid_ff;
      snap_in          = snap_ff;
      id_in            = id_ff;
      rank_in          = rank_ff;
      next_id_in       = next_id_ff;
      link_up_in       = link_up_ff;
      last_ping_in     = last_ping_ff;
      last_rx_in       = last_rx_ff;
      ping_due_in      = ping_due_ff;
      lost_in          = lost_ff;
      scan_in          = scan_ff;
      pick_in          = pick_ff;
      rd_pend_in       = rd_pend_ff;
      rd_slot_in       = rd_slot_ff;
      look_hit_in      = look_hit_ff;
      look_slot_in     = look_slot_ff;
      mem_we           = 1'b0;
      mem_waddr        = '0;
      mem_wdata        = '0;
      mem_re           = 1'b0;
      mem_raddr        = '0;
      new_valid        = 1'b0;
      new_rsp          = '0;
      fin              = 1'b0;
      w                = mem_rdata_ff;

      if (csr_we) begin
         case (csr_index)
            lkrt_pkg::CSR_PING_INTERVAL: ping_interval_in = csr_wdata;
            lkrt_pkg::CSR_QUIET:         quiet_in         = csr_wdata;
            lkrt_pkg::CSR_LOST_AFTER:    lost_after_in    = csr_wdata;
            lkrt_pkg::CSR_STALE_LIMIT:   stale_limit_in   = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in = req_data;
               case (req_data.mode)
                  lkrt_pkg::MODE_TICK: begin
                     snap_in = valid_ff;
                     for (int i = 0; i < DEPTH; i++) begin
                        rank_in[i] = '0;
                     end
                     scan_in = '0;
                     // keepalive decisions do not depend on the sweep
                     ping_due_in = (req_data.now_ms - last_ping_ff) > {16'd0, ping_interval_ff}
                        && (!link_up_ff
                            || (req_data.now_ms - last_rx_ff) > {16'd0, quiet_ff});
                     lost_in = link_up_ff
                        && (req_data.now_ms - last_rx_ff) > {16'd0, lost_after_ff};
                     if (ping_due_in) begin
                        last_ping_in = req_data.now_ms;
                     end
                     if (lost_in) begin
                        link_up_in = 1'b0;
                     end
                     state_in = S_RANK;
                  end
                  lkrt_pkg::MODE_PING: begin
                     last_rx_in     = req_data.now_ms;
                     new_valid      = 1'b1;
                     new_rsp.kind   = lkrt_pkg::KIND_PONG;
                     state_in       = S_FIN;
                  end
                  lkrt_pkg::MODE_PONG: begin
                     last_rx_in = req_data.now_ms;
                     if (!link_up_ff) begin
                        link_up_in   = 1'b1;
                        new_valid    = 1'b1;
                        new_rsp.kind = lkrt_pkg::KIND_LINK_UP;
                     end
                     state_in = S_FIN;
                  end
                  lkrt_pkg::MODE_RESP, lkrt_pkg::MODE_CLOSE, lkrt_pkg::MODE_QUERY: begin
                     if (req_data.mode == lkrt_pkg::MODE_RESP) begin
                        last_rx_in = req_data.now_ms;
                     end
                     look_hit_in  = req_hit;
                     look_slot_in = req_slot;
                     mem_re       = req_hit;
                     mem_raddr    = req_slot;
                     state_in     = S_LOOK;
                  end
                  lkrt_pkg::MODE_OTHER: begin
                     last_rx_in = req_data.now_ms;
                     state_in   = S_FIN;
                  end
                  lkrt_pkg::MODE_NEW: begin
                     next_id_in        = next_id_ff + 32'd1;
                     new_valid         = 1'b1;
                     new_rsp.result_id = next_id_ff;
                     if (nid_hit) begin
                        // id wrapped onto a live entry: sent but not tracked
                        new_rsp.kind = lkrt_pkg::KIND_SEND;
                     end else if (!free_any) begin
                        new_rsp.kind = lkrt_pkg::KIND_FULL;
                     end else begin
                        new_rsp.kind        = lkrt_pkg::KIND_SEND;
                        valid_in[free_slot] = 1'b1;
                        id_in[free_slot]    = next_id_ff;
                        mem_we              = 1'b1;
                        mem_waddr           = free_slot;
                        mem_wdata.status    = lkrt_pkg::ST_SENT;
                        mem_wdata.id        = next_id_ff;
                        mem_wdata.sent_time = req_data.now_ms;
                        mem_wdata.timeout   = req_data.timeout_ms;
                        mem_wdata.response  = '0;
                     end
                     state_in = S_FIN;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end

         S_RANK: begin
            // rank of a slot = number of live ids below its own
            for (int i = 0; i < DEPTH; i++) begin
               if (scan_ok && scan_id < id_ff[i]) begin
                  rank_in[i] = rank_ff[i] + SW'(1);
               end
            end
            scan_in = scan_ff + SW'(1);
            if (scan_ff == SW'(DEPTH - 1)) begin
               pick_in    = '0;
               rd_pend_in = 1'b0;
               state_in   = S_PICK;
            end
         end

         S_PICK: begin
            // read of the next slot overlaps evaluation of the previous one
            rd_pend_in = pick_any;
            rd_slot_in = pick_slot;
            mem_re     = pick_any;
            mem_raddr  = pick_slot;
            pick_in    = pick_ff + PW'(1);
            if (rd_pend_ff) begin
               new_rsp.result_id = mem_rdata_ff.id;
               if (mem_rdata_ff.status inside {lkrt_pkg::ST_CLOSED, lkrt_pkg::ST_TIMEOUT}) begin
                  valid_in[rd_slot_ff] = 1'b0;
                  new_valid            = 1'b1;
                  new_rsp.kind         = lkrt_pkg::KIND_REMOVED;
               end else if (age > {16'd0, stale_limit_ff}) begin
                  w.status     = lkrt_pkg::ST_CLOSED;
                  mem_we       = 1'b1;
                  mem_waddr    = rd_slot_ff;
                  mem_wdata    = w;
                  new_valid    = 1'b1;
                  new_rsp.kind = lkrt_pkg::KIND_STALE;
               end else if (mem_rdata_ff.status == lkrt_pkg::ST_SENT
                            && age >= {1'b0, mem_rdata_ff.timeout}) begin
                  valid_in[rd_slot_ff] = 1'b0;
                  new_valid            = 1'b1;
                  new_rsp.kind         = lkrt_pkg::KIND_TIMED_OUT;
               end
            end
            if (!pick_any && !rd_pend_ff) begin
               state_in = S_PING;
            end
         end

         S_PING: begin
            if (ping_due_ff) begin
               new_valid    = 1'b1;
               new_rsp.kind = lkrt_pkg::KIND_PING;
            end
            state_in = S_LOST;
         end

         S_LOST: begin
            if (lost_ff) begin
               new_valid    = 1'b1;
               new_rsp.kind = lkrt_pkg::KIND_LINK_DOWN;
            end
            state_in = S_FIN;
         end

         S_LOOK: begin
            case (item_ff.mode)
               lkrt_pkg::MODE_RESP: begin
                  w.status   = lkrt_pkg::ST_OK;
                  w.response = item_ff.response_data;
                  mem_we     = look_hit_ff;
                  mem_waddr  = look_slot_ff;
                  mem_wdata  = w;
               end
               lkrt_pkg::MODE_CLOSE: begin
                  w.status          = lkrt_pkg::ST_CLOSED;
                  mem_we            = look_hit_ff;
                  mem_waddr         = look_slot_ff;
                  mem_wdata         = w;
                  new_valid         = 1'b1;
                  new_rsp.kind      = lkrt_pkg::KIND_CLOSE_RES;
                  new_rsp.result_id = item_ff.request_id;
                  new_rsp.found     = look_hit_ff;
               end
               lkrt_pkg::MODE_QUERY: begin
                  new_valid           = 1'b1;
                  new_rsp.kind        = lkrt_pkg::KIND_QUERY_RES;
                  new_rsp.result_id   = item_ff.request_id;
                  new_rsp.found       = look_hit_ff;
                  new_rsp.result_data = look_hit_ff ? mem_rdata_ff.response : 32'd0;
               end
               default: ;
            endcase
            state_in = S_FIN;
         end

         S_FIN: begin
            fin      = 1'b1;
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // one beat is held back so the final one can carry last
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      if (new_valid) begin
         if (hold_valid_ff) begin
            rsp_in        = hold_ff;
            rsp_in.last   = 1'b0;
            rsp_strobe_in = 1'b1;
         end
         hold_in       = new_rsp;
         hold_valid_in = 1'b1;
      end
      if (fin && hold_valid_ff) begin
         rsp_in        = hold_ff;
         rsp_in.last   = 1'b1;
         rsp_strobe_in = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         ping_interval_ff <= lkrt_pkg::PING_INTERVAL_RST;
         quiet_ff         <= lkrt_pkg::QUIET_RST;
         lost_after_ff    <= lkrt_pkg::LOST_AFTER_RST;
         stale_limit_ff   <= lkrt_pkg::STALE_LIMIT_RST;
         valid_ff         <= '0;
         next_id_ff       <= '0;
         link_up_ff       <= 1'b0;
         last_ping_ff     <= '0;
         last_rx_ff       <= '0;
         rd_pend_ff       <= 1'b0;
         hold_valid_ff    <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         ping_interval_ff <= ping_interval_in;
         quiet_ff         <= quiet_in;
         lost_after_ff    <= lost_after_in;
         stale_limit_ff   <= stale_limit_in;
         valid_ff         <= valid_in;
         next_id_ff       <= next_id_in;
         link_up_ff       <= link_up_in;
         last_ping_ff     <= last_ping_in;
         last_rx_ff       <= last_rx_in;
         rd_pend_ff       <= rd_pend_in;
         hold_valid_ff    <= hold_valid_in;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      snap_ff      <= snap_in;
      id_ff        <= id_in;
      rank_ff      <= rank_in;
      ping_due_ff  <= ping_due_in;
      lost_ff      <= lost_in;
      scan_ff      <= scan_in;
      pick_ff      <= pick_in;
      rd_slot_ff   <= rd_slot_in;
      look_hit_ff  <= look_hit_in;
      look_slot_ff <= look_slot_in;
      hold_ff      <= hold_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

### verif/lkrt_result_checker.sv
`timescale 1ns / 1ps

module lkrt_result_checker
   import lkrt_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire         busy,
   input  req_type     req_data,
   input  wire         rsp_strobe,
   input  rsp_type     rsp_data,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata,
   output int          mismatch_count,
   output int          outstanding
);

   logic [15:0] ping_gap;
   logic [15:0] quiet_ms;
   logic [15:0] lost_ms;
   logic [15:0] stale_ms;

   bit          slot_live   [TABLE_DEPTH];
   logic [31:0] slot_tag    [TABLE_DEPTH];
   logic [1:0]  slot_state  [TABLE_DEPTH];
   logic [31:0] slot_born   [TABLE_DEPTH];
   logic [30:0] slot_limit  [TABLE_DEPTH];
   logic [31:0] slot_handle [TABLE_DEPTH];

   logic [31:0] id_counter;
   logic [31:0] last_ping_ms;
   logic [31:0] last_heard_ms;
   bit          link_up;

   rsp_type     owed_beats [$];

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_model();
      mismatch_count = 0;
      ping_gap = PING_INTERVAL_RST;
      quiet_ms = QUIET_RST;
      lost_ms  = LOST_AFTER_RST;
      stale_ms = STALE_LIMIT_RST;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_live[i] = 1'b0;
      end
      id_counter    = '0;
      last_ping_ms  = '0;
      last_heard_ms = '0;
      link_up       = 1'b0;
      owed_beats.delete();
   endtask

   function automatic int slot_holding(logic [31:0] id);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_live[i] && slot_tag[i] == id) return i;
      end
      return -1;
   endfunction

   task automatic owe(logic [3:0] kind, logic [31:0] id, logic found, logic [31:0] data);
      rsp_type beat;
      beat.kind        = kind;
      beat.result_id   = id;
      beat.found       = found;
      beat.result_data = data;
      beat.last        = 1'b0;
      owed_beats.push_back(beat);
   endtask

   // visits live slots in ascending id order
   task automatic sweep_table(logic [31:0] now);
      bit          visited [TABLE_DEPTH];
      int          pick;
      logic [31:0] age;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         visited[i] = 1'b0;
      end
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         pick = -1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_live[i] && !visited[i]) begin
               if (pick < 0) pick = i;
               else if (slot_tag[i] < slot_tag[pick]) pick = i;
            end
         end
         if (pick < 0) break;
         visited[pick] = 1'b1;
         age = now - slot_born[pick];
         if (slot_state[pick] == ST_CLOSED || slot_state[pick] == ST_TIMEOUT) begin
            slot_live[pick] = 1'b0;
            owe(KIND_REMOVED, slot_tag[pick], 1'b0, '0);
         end else if (age > {16'd0, stale_ms}) begin
            slot_state[pick] = ST_CLOSED;
            owe(KIND_STALE, slot_tag[pick], 1'b0, '0);
         end else if (slot_state[pick] == ST_SENT && age >= {1'b0, slot_limit[pick]}) begin
            slot_live[pick] = 1'b0;
            owe(KIND_TIMED_OUT, slot_tag[pick], 1'b0, '0);
         end
      end
   endtask

   task automatic predict_item(req_type item);
      int          owed_prior;
      int          s;
      logic [31:0] now;
      logic [31:0] rid;
      logic [31:0] id;
      logic [31:0] since_ping;
      logic [31:0] since_heard;
      owed_prior = owed_beats.size();
      now        = item.now_ms;
      rid        = item.request_id;
      case (item.mode)
         MODE_TICK: begin
            sweep_table(now);
            since_ping  = now - last_ping_ms;
            since_heard = now - last_heard_ms;
            if (since_ping > {16'd0, ping_gap} &&
                (!link_up || since_heard > {16'd0, quiet_ms})) begin
               owe(KIND_PING, '0, 1'b0, '0);
               last_ping_ms = now;
            end
            if (link_up && since_heard > {16'd0, lost_ms}) begin
               link_up = 1'b0;
               owe(KIND_LINK_DOWN, '0, 1'b0, '0);
            end
         end
         MODE_PING: begin
            last_heard_ms = now;
            owe(KIND_PONG, '0, 1'b0, '0);
         end
         MODE_PONG: begin
            last_heard_ms = now;
            if (!link_up) begin
               link_up = 1'b1;
               owe(KIND_LINK_UP, '0, 1'b0, '0);
            end
         end
         MODE_RESP: begin
            last_heard_ms = now;
            s = slot_holding(rid);
            if (s >= 0) begin
               slot_state[s]  = ST_OK;
               slot_handle[s] = item.response_data;
            end
         end
         MODE_OTHER: begin
            last_heard_ms = now;
         end
         MODE_NEW: begin
            id         = id_counter;
            id_counter = id_counter + 1;
            if (slot_holding(id) >= 0) begin
               // id wrapped onto a live entry: sent but not tracked
               owe(KIND_SEND, id, 1'b0, '0);
            end else begin
               s = -1;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (s < 0 && !slot_live[i]) s = i;
               end
               if (s < 0) begin
                  owe(KIND_FULL, id, 1'b0, '0);
               end else begin
                  slot_live[s]   = 1'b1;
                  slot_tag[s]    = id;
                  slot_state[s]  = ST_SENT;
                  slot_born[s]   = now;
                  slot_limit[s]  = item.timeout_ms;
                  slot_handle[s] = '0;
                  owe(KIND_SEND, id, 1'b0, '0);
               end
            end
         end
         MODE_CLOSE: begin
            s = slot_holding(rid);
            if (s >= 0) slot_state[s] = ST_CLOSED;
            owe(KIND_CLOSE_RES, rid, s >= 0, '0);
         end
         default: begin
            s = slot_holding(rid);
            owe(KIND_QUERY_RES, rid, s >= 0, (s >= 0) ? slot_handle[s] : 32'd0);
         end
      endcase
      if (owed_beats.size() > owed_prior) owed_beats[owed_beats.size() - 1].last = 1'b1;
   endtask

   task automatic check_beat(rsp_type got);
      rsp_type want;
      if (owed_beats.size() == 0) begin
         report("beat with nothing owed, kind", 32'(got.kind), '0);
      end else begin
         want = owed_beats.pop_front();
         if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
         if (got.result_id !== want.result_id) report("result_id", got.result_id, want.result_id);
         if (got.found !== want.found) report("found", 32'(got.found), 32'(want.found));
         if (got.result_data !== want.result_data)
            report("result_data", got.result_data, want.result_data);
         if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (rsp_strobe) check_beat(rsp_data);
         if (csr_we) begin
            case (csr_index)
               CSR_PING_INTERVAL: ping_gap = csr_wdata;
               CSR_QUIET:         quiet_ms = csr_wdata;
               CSR_LOST_AFTER:    lost_ms  = csr_wdata;
               default:           stale_ms = csr_wdata;
            endcase
         end
         if (start && !busy) predict_item(req_data);
      end
      outstanding <= owed_beats.size();
   end

endmodule

### verif/link_keepalive_request_tracker_core_tb.sv
`timescale 1ns / 1ps

module link_keepalive_request_tracker_core_tb;
   import lkrt_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 48;
   localparam int DIRECTED      = 20;
   localparam int PHASE_ITEMS   = 50;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   int          mismatch_count;
   int          outstanding;
   int          cycle_count = 0;
   int          item_count  = 0;
   int          calm_left   = 0;
   logic [31:0] wall_ms     = '0;
   logic [31:0] ids_issued  = '0;

   link_keepalive_request_tracker_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lkrt_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[link_keepalive_request_tracker_core] ERROR");
         $finish;
      end
   end

   // start stays high across back-to-back beats
   task automatic send_beat(req_type item);
      int gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 15);
         if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      item_count++;
      if (item.mode == MODE_NEW) ids_issued++;
   endtask

   task automatic issue(logic [2:0] mode, logic [31:0] now, logic [31:0] id,
                        logic [30:0] tmo, logic [31:0] data);
      req_type item;
      item.mode          = mode;
      item.now_ms        = now;
      item.request_id    = id;
      item.timeout_ms    = tmo;
      item.response_data = data;
      send_beat(item);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(logic [15:0] ping, logic [15:0] quiet,
                             logic [15:0] lost, logic [15:0] stale);
      csr_we    <= 1'b1;
      csr_index <= CSR_PING_INTERVAL;
      csr_wdata <= ping;
      @(posedge clock);
      csr_index <= CSR_QUIET;
      csr_wdata <= quiet;
      @(posedge clock);
      csr_index <= CSR_LOST_AFTER;
      csr_wdata <= lost;
      @(posedge clock);
      csr_index <= CSR_STALE_LIMIT;
      csr_wdata <= stale;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly recent ids, some arbitrary ones
   function automatic logic [31:0] pick_id();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return ids_issued - 1 - $urandom_range(0, 24);
   endfunction

   function automatic logic [30:0] pick_timeout();
      int          r;
      logic [31:0] v;
      r = $urandom_range(0, 9);
      if (r < 7) v = $urandom_range(0, 2500);
      else if (r < 9) v = $urandom_range(0, 70000);
      else v = $urandom();
      return v[30:0];
   endfunction

   // time runs forward with occasional jumps; a few beats carry a random time
   function automatic logic [31:0] next_now();
      int r;
      r = $urandom_range(0, 19);
      if (r < 2) return $urandom();
      if (r < 14) wall_ms = wall_ms + $urandom_range(0, 300);
      else if (r < 19) wall_ms = wall_ms + $urandom_range(0, 3000);
      else wall_ms = wall_ms + $urandom_range(0, 100000);
      return wall_ms;
   endfunction

   task automatic random_step();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         // burst of new requests to fill the table
         n = $urandom_range(16, 20);
         repeat (n) issue(MODE_NEW, next_now(), $urandom(), pick_timeout(), $urandom());
      end else if (r < 30) begin
         issue(MODE_TICK, next_now(), $urandom(), pick_timeout(), $urandom());
      end else if (r < 38) begin
         issue(MODE_PING, next_now(), $urandom(), pick_timeout(), $urandom());
      end else if (r < 46) begin
         issue(MODE_PONG, next_now(), $urandom(), pick_timeout(), $urandom());
      end else if (r < 60) begin
         issue(MODE_RESP, next_now(), pick_id(), pick_timeout(), $urandom());
      end else if (r < 64) begin
         issue(MODE_OTHER, next_now(), $urandom(), pick_timeout(), $urandom());
      end else if (r < 82) begin
         issue(MODE_NEW, next_now(), $urandom(), pick_timeout(), $urandom());
      end else if (r < 90) begin
         issue(MODE_CLOSE, next_now(), pick_id(), pick_timeout(), $urandom());
      end else begin
         issue(MODE_QUERY, next_now(), pick_id(), pick_timeout(), $urandom());
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_PING_INTERVAL;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset register values
      issue(MODE_TICK,  32'd0, 32'd0, 31'd0, 32'd0);
      issue(MODE_QUERY, 32'd0, 32'd0, 31'd0, 32'd0);
      issue(MODE_CLOSE, 32'd0, 32'hFFFF_FFFF, 31'd0, 32'd0);
      issue(MODE_NEW,   32'd100, 32'd0, 31'd0, 32'd0);
      issue(MODE_NEW,   32'd100, 32'd0, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      issue(MODE_NEW,   32'd100, 32'd0, 31'd300, 32'd0);
      issue(MODE_RESP,  32'd150, 32'd1, 31'd0, 32'hFFFF_FFFF);
      // response to an unknown id is dropped
      issue(MODE_RESP,  32'd150, 32'hFFFF_FFFF, 31'd0, 32'h1234_5678);
      issue(MODE_QUERY, 32'd160, 32'd1, 31'd0, 32'd0);
      issue(MODE_CLOSE, 32'd170, 32'd2, 31'd0, 32'd0);
      // zero timeout expires, closed entry removed, ping while link down
      issue(MODE_TICK,  32'd600, 32'd0, 31'd0, 32'd0);
      issue(MODE_PING,  32'd700, 32'd0, 31'd0, 32'd0);
      issue(MODE_PONG,  32'd700, 32'd0, 31'd0, 32'd0);
      issue(MODE_PONG,  32'd710, 32'd0, 31'd0, 32'd0);
      issue(MODE_OTHER, 32'd800, 32'd0, 31'd0, 32'd0);
      issue(MODE_TICK,  32'd1200, 32'd0, 31'd0, 32'd0);
      // response to a closed entry reopens it as ok
      issue(MODE_RESP,  32'd1250, 32'd1, 31'd0, 32'd0);
      issue(MODE_QUERY, 32'd1260, 32'd1, 31'd0, 32'd0);
      issue(MODE_TICK,  32'hFFFF_FFFF, 32'd0, 31'd0, 32'd0);
      // time wraps past zero
      issue(MODE_TICK,  32'h0000_0010, 32'd0, 31'd0, 32'd0);
      settle();

      wall_ms = 32'd2000;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_regs(PING_INTERVAL_RST, QUIET_RST, LOST_AFTER_RST, STALE_LIMIT_RST);
            1: write_regs(16'd0, 16'd0, 16'd0, 16'd0);
            2: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: write_regs(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                          16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
            4: write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            default: write_regs(16'($urandom_range(0, 1200)), 16'($urandom_range(0, 1200)),
                                16'($urandom_range(0, 1200)), 16'($urandom_range(0, 1200)));
         endcase
         if (phase == 3) wall_ms = 32'hFFFF_E000;
         while (item_count < DIRECTED + (phase + 1) * PHASE_ITEMS) random_step();
         settle();
      end

      if (mismatch_count == 0) begin
         $display("[link_keepalive_request_tracker_core] OK");
      end else begin
         $display("[link_keepalive_request_tracker_core] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/lkrt_pkg.sv
hw/rtl/link_keepalive_request_tracker_core.sv
verif/lkrt_result_checker.sv
verif/link_keepalive_request_tracker_core_tb.sv
